// File: rtl/icmr_pkg.sv
package icmr_pkg;

    localparam int LANES   = 4;
    localparam int DATA_W  = 8;
    localparam int LPROD_W = 2 * DATA_W;
    localparam int ACC_W   = 32;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = ACC_W + COEF_W;

    localparam int QM_SHIFT    = 15;
    localparam int RELU_POS_SH = 14;
    localparam int RELU_NEG_SH = 17;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = COEF_W;

    localparam logic [CFG_IDX_W-1:0] CFG_M0         = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_SCALE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_EN     = CFG_IDX_W'(2);

    localparam logic signed [COEF_W-1:0] M0_RESET   = COEF_W'(16384);
    localparam logic signed [COEF_W-1:0] RELU_RESET = COEF_W'(16384);

    typedef logic signed [DATA_W-1:0] t_lane;

    typedef struct packed {
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] bias;
    } t_mac_req;

    typedef struct packed {
        logic signed [COEF_W-1:0] m0;
        logic signed [COEF_W-1:0] relu_scale;
        logic                     act_en;
    } t_cfg;

endpackage

// File: rtl/icmr_front.sv
module icmr_front
    import icmr_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  t_lane                   i_act [LANES],
    input  t_lane                   i_wt  [LANES],
    input  logic signed [ACC_W-1:0] i_bias,
    input  logic                    i_first,
    input  logic                    i_last,
    output logic                    o_wr,
    output t_mac_req                o_req
);

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;

    always_comb begin
        logic signed [LPROD_W-1:0] prod;
        n_acc = i_first ? '0 : r_acc;
        for (int i = 0; i < LANES; i++) begin
            prod  = i_act[i] * i_wt[i];
            n_acc = n_acc + {{(ACC_W - LPROD_W){prod[LPROD_W-1]}}, prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_accept) begin
            r_acc <= n_acc;
        end
    end

    // only last requests go on to requantization
    assign o_wr       = i_accept && i_last;
    assign o_req.acc  = n_acc;
    assign o_req.bias = i_bias;

endmodule

// File: rtl/icmr_queue.sv
module icmr_queue
    import icmr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr,
    input  t_mac_req i_data,
    input  logic     i_rd,
    output logic     o_valid,
    output logic     o_full,
    output t_mac_req o_data
);

    t_mac_req          r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_data  = r_mem[r_rd_ptr];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("queue written while full");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a write");
`endif

endmodule

// File: rtl/icmr_back.sv
module icmr_back
    import icmr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    input  t_mac_req           i_req,
    output logic               o_rd,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [DATA_W-1:0] o_result
);

    logic r_v1, r_v2, r_v3, r_vo;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [ACC_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_prod1;
    logic signed [PROD_W-1:0] r_prod2;
    logic                     r_neg;
    logic                     r_act;
    logic [DATA_W-1:0]        r_v1_lo;
    logic [DATA_W-1:0]        r_out;

    logic [ACC_W-1:0]         n_sum;
    logic signed [PROD_W-1:0] n_prod1;
    logic [ACC_W-1:0]         n_v1;
    logic signed [PROD_W-1:0] n_prod2;
    logic [DATA_W-1:0]        n_out;

    assign rdy4 = !r_vo || i_pop;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_rd = i_valid && rdy1;

    always_comb begin
        n_sum   = i_req.acc + i_req.bias;
        n_prod1 = $signed({{(PROD_W - ACC_W){r_sum[ACC_W-1]}}, r_sum})
                * $signed({{(PROD_W - COEF_W){i_cfg.m0[COEF_W-1]}}, i_cfg.m0});
        n_v1    = r_prod1[QM_SHIFT +: ACC_W];
        n_prod2 = $signed({{(PROD_W - ACC_W){n_v1[ACC_W-1]}}, n_v1})
                * $signed({{(PROD_W - COEF_W){i_cfg.relu_scale[COEF_W-1]}},
                           i_cfg.relu_scale});
        // leaky slope for negative values when act_en is set; otherwise the low byte passes through
        if (!r_act) begin
            n_out = r_v1_lo;
        end else if (r_neg) begin
            n_out = r_prod2[RELU_NEG_SH +: DATA_W];
        end else begin
            n_out = r_prod2[RELU_POS_SH +: DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_sum <= n_sum;
        end
        if (rdy2) begin
            r_prod1 <= n_prod1;
        end
        if (rdy3) begin
            r_prod2 <= n_prod2;
            r_neg   <= n_v1[ACC_W-1];
            r_act   <= i_cfg.act_en;
            r_v1_lo <= n_v1[DATA_W-1:0];
        end
        if (rdy4) begin
            r_out <= n_out;
        end
    end

    assign o_empty  = !r_vo;
    assign o_result = r_out;

`ifndef SYNTHESIS
    a_rd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd |-> i_valid)
        else $error("queue read without a waiting request");
`endif

endmodule

// File: rtl/int8_conv_mac_requantize_unit.sv
// channel   direction  handshake        payload
// input     in         push / full      act_0..3, wt_0..3, bias_value, first, last
// result    out        pop / empty      result_value
// config    in         i_cfg_we         i_cfg_index, i_cfg_data
//
// one request accepted per cycle unless full; the mac front updates the
// accumulator at accept; a last request reaches the result register through a
// 4-entry queue and the add, m0 multiply and scale multiply stages
// reset is synchronous active low and clears accumulator, queue and stage valids
// a stalled result holds the back stages; full rises when the queue fills
module int8_conv_mac_requantize_unit
    import icmr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [DATA_W-1:0] i_act_0,
    input  logic signed [DATA_W-1:0] i_act_1,
    input  logic signed [DATA_W-1:0] i_act_2,
    input  logic signed [DATA_W-1:0] i_act_3,
    input  logic signed [DATA_W-1:0] i_wt_0,
    input  logic signed [DATA_W-1:0] i_wt_1,
    input  logic signed [DATA_W-1:0] i_wt_2,
    input  logic signed [DATA_W-1:0] i_wt_3,
    input  logic signed [ACC_W-1:0]  i_bias_value,
    input  logic                     i_first,
    input  logic                     i_last,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] o_result_value,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data
);

    t_cfg     r_cfg;
    t_lane    act [LANES];
    t_lane    wt  [LANES];
    logic     accept;
    logic     q_wr;
    logic     q_rd;
    logic     q_valid;
    t_mac_req q_in;
    t_mac_req q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.m0         <= M0_RESET;
            r_cfg.relu_scale <= RELU_RESET;
            r_cfg.act_en     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_M0:         r_cfg.m0         <= i_cfg_data;
                CFG_RELU_SCALE: r_cfg.relu_scale <= i_cfg_data;
                CFG_ACT_EN:     r_cfg.act_en     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign act[0] = i_act_0;
    assign act[1] = i_act_1;
    assign act[2] = i_act_2;
    assign act[3] = i_act_3;
    assign wt[0]  = i_wt_0;
    assign wt[1]  = i_wt_1;
    assign wt[2]  = i_wt_2;
    assign wt[3]  = i_wt_3;

    assign accept = push && !full;

    icmr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_act    (act),
        .i_wt     (wt),
        .i_bias   (i_bias_value),
        .i_first  (i_first),
        .i_last   (i_last),
        .o_wr     (q_wr),
        .o_req    (q_in)
    );

    icmr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_full  (full),
        .o_data  (q_out)
    );

    icmr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (q_valid),
        .i_req    (q_out),
        .o_rd     (q_rd),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result_value)
    );

endmodule
